[design/rfca_pkg.sv]
// ----------------------------------------------------------------------------
// rfca_pkg
// Shared types, codes and constants of the range frame checker / averager.
// ----------------------------------------------------------------------------
package rfca_pkg;

    // Frame layout
    localparam int          FRAME_BYTES = 11;
    localparam int          POS_W       = 4;
    localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DIST_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DIST_HI = POS_W'(3);
    localparam logic [POS_W-1:0] POS_STR_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_STR_HI  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_CKSUM   = POS_W'(FRAME_BYTES - 1);
    localparam logic [7:0]  HDR_BYTE    = 8'h59;

    // Sample qualification
    localparam logic [15:0] STRENGTH_MIN  = 16'd100;
    localparam logic [15:0] STRENGTH_SAT  = 16'hFFFF;
    localparam logic [15:0] DIST_MAX_CM   = 16'd1200;
    localparam logic [15:0] DIST_MIN_CM   = 16'd10;
    localparam logic [15:0] OOR_ADD_CM    = 16'd100;

    // Accumulator
    localparam int          SUM_W           = 24;
    localparam int          AVG_W           = 16;
    localparam int          DEF_MAX_SAMPLES = 255;

    // Configuration registers
    localparam int          MAX_RANGE_W   = 15;
    localparam int          TIMEOUT_W     = 16;
    localparam int          APB_ADDR_W    = 3;
    localparam int          APB_DATA_W    = 32;
    localparam logic [MAX_RANGE_W-1:0] DEF_MAX_RANGE = MAX_RANGE_W'(1200);
    localparam logic [TIMEOUT_W-1:0]   DEF_TIMEOUT   = TIMEOUT_W'(200);
    localparam logic REG_MAX_RANGE = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // Word codes
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;
    localparam logic [1:0] UPD_NEW     = 2'd0;
    localparam logic [1:0] UPD_TIMEOUT = 2'd1;
    localparam logic [1:0] UPD_NOTHING = 2'd2;

endpackage

[design/rfca_if.sv]
// ----------------------------------------------------------------------------
// rfca request / result channels
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface rfca_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;

    modport source (output valid, req_type, rx_byte, now_ms, input ready);
    modport sink   (input valid, req_type, rx_byte, now_ms, output ready);
endinterface

interface rfca_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        frame_good;
    logic [15:0] sample_cm;
    logic [15:0] average_cm;
    logic [1:0]  upd_code;

    modport source (output valid, result_kind, frame_good, sample_cm, average_cm,
                    upd_code, input ready);
    modport sink   (input valid, result_kind, frame_good, sample_cm, average_cm,
                    upd_code, output ready);
endinterface

[design/rfca_div.sv]
// ----------------------------------------------------------------------------
// rfca_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfca_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 8,
    parameter int QUOT_W     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [QUOT_W-1:0]     o_quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W+1:0]  w_diff;
    logic                  w_bit;

    // partial remainder with next dividend bit shifted in
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_bit   = ~w_diff[DIVISOR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_bit ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
                r_quo  <= {r_quo[DIVIDEND_W-2:0], w_bit};
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QUOT_W-1:0];

endmodule

[design/range_frame_checker_averager.sv]
// ----------------------------------------------------------------------------
// range_frame_checker_averager
// Ranging sensor frame parser with sample qualification and averaging.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one word per handshake: either a received sensor byte
//   (req_type 0) or an update request (req_type 1, with now_ms).
//   o_res returns at most one word per request: a frame verdict on the
//   checksum byte of each frame, and an update answer for each update.
//   Header bytes 0x59 resync the parser; other bytes give no result word.
//   A byte that gives no word passes through S_BYTE back to idle. A
//   checksum byte passes S_BYTE, then S_QUAL on a good frame, and S_EMIT
//   into the output register. An update with samples goes through S_UPD,
//   then S_DIV, where the restoring divider yields one quotient bit per
//   cycle, then S_EMIT; an update with no samples goes from S_UPD straight
//   to S_EMIT.
//   One request is in flight at a time: ready is high only in the idle
//   state, but a finished word may sit in the output register while the
//   next request is taken. If the receiver stalls, the next result waits in
//   a pending stage and no further request is taken until it moves.
//   Reset (synchronous, active low) clears the parser, sum, count, the
//   last-average time and loads the register defaults (max range 1200 cm,
//   timeout 200 ms).
//   APB: register 0 (addr 0) max_range_cm, register 1 (addr 4)
//   nodata_timeout_ms; write only while idle.
// ----------------------------------------------------------------------------
module range_frame_checker_averager
    import rfca_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rfca_req_if.sink              i_req,
    rfca_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_QUAL,
        S_UPD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;

    // config
    logic [MAX_RANGE_W-1:0] r_max_range;
    logic [TIMEOUT_W-1:0]   r_timeout;

    // latched request
    logic [7:0]  r_byte;
    logic [31:0] r_now;

    // parser and accumulator
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_cks;
    logic [15:0]      r_dist;
    logic [15:0]      r_str;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_last;

    // pending result word
    logic             r_p_kind;
    logic             r_p_good;
    logic [15:0]      r_p_sample;
    logic [AVG_W-1:0] r_p_avg;
    logic [1:0]       r_p_status;

    // output register
    logic             r_o_valid;
    logic             r_o_kind;
    logic             r_o_good;
    logic [15:0]      r_o_sample;
    logic [AVG_W-1:0] r_o_avg;
    logic [1:0]       r_o_status;

    // divider hookup
    logic             w_div_start;
    logic             w_div_done;
    logic [AVG_W-1:0] w_div_quo;

    // qualification
    logic [15:0] w_alt;
    logic [15:0] w_subst;
    logic        w_unreliable;
    logic [15:0] w_sample;

    // timeout check
    logic [31:0] w_elapsed;
    logic        w_timed_out;

    logic w_cfg_wr;
    logic w_out_free;

    assign w_alt        = {1'b0, r_max_range} + OOR_ADD_CM;
    assign w_subst      = (w_alt > DIST_MAX_CM) ? w_alt : DIST_MAX_CM;
    assign w_unreliable = (r_str < STRENGTH_MIN) || (r_str == STRENGTH_SAT) ||
                          (r_dist > DIST_MAX_CM);
    assign w_sample     = w_unreliable ? w_subst :
                          ((r_dist < DIST_MIN_CM) ? DIST_MIN_CM : r_dist);

    // elapsed time wraps modulo 2^32
    assign w_elapsed   = r_now - r_last;
    assign w_timed_out = w_elapsed > {16'd0, r_timeout};

    assign w_div_start = (r_state == S_UPD) && (r_cnt != '0);

    rfca_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (AVG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // APB: always ready, register picked by paddr[2]
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_TIMEOUT) ? APB_DATA_W'(r_timeout)
                                                : APB_DATA_W'(r_max_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= DEF_MAX_RANGE;
            r_timeout   <= DEF_TIMEOUT;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_TIMEOUT) begin
                r_timeout <= pwdata[TIMEOUT_W-1:0];
            end else begin
                r_max_range <= pwdata[MAX_RANGE_W-1:0];
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_free  = !r_o_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_cks     <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // word taken; in S_EMIT the next word reloads the register instead
            if (r_o_valid && o_res.ready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_byte     <= i_req.rx_byte;
                        r_now      <= i_req.now_ms;
                        r_state    <= (i_req.req_type == REQ_UPDATE) ? S_UPD : S_BYTE;
                    end
                end

                S_BYTE: begin
                    r_p_kind   <= KIND_FRAME;
                    r_p_good   <= 1'b0;
                    r_p_sample <= '0;
                    r_p_avg    <= '0;
                    r_p_status <= UPD_NEW;
                    if ((r_pos <= POS_HDR1) && (r_byte != HDR_BYTE)) begin
                        // lost sync: restart the frame
                        r_pos   <= '0;
                        r_cks   <= '0;
                        r_state <= S_IDLE;
                    end else if (r_pos >= POS_CKSUM) begin
                        r_pos   <= '0;
                        r_cks   <= '0;
                        r_state <= (r_cks == r_byte) ? S_QUAL : S_EMIT;
                    end else begin
                        case (r_pos)
                            POS_DIST_LO: r_dist[7:0]  <= r_byte;
                            POS_DIST_HI: r_dist[15:8] <= r_byte;
                            POS_STR_LO:  r_str[7:0]   <= r_byte;
                            POS_STR_HI:  r_str[15:8]  <= r_byte;
                            default: ;
                        endcase
                        r_cks   <= (r_pos == '0) ? r_byte : r_cks + r_byte;
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_IDLE;
                    end
                end

                S_QUAL: begin
                    r_p_good   <= 1'b1;
                    r_p_sample <= w_sample;
                    // a full accumulator drops the sample
                    if (r_cnt < CNT_MAX) begin
                        r_sum <= r_sum + SUM_W'(w_sample);
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_state <= S_EMIT;
                end

                S_UPD: begin
                    r_p_kind   <= KIND_UPDATE;
                    r_p_good   <= 1'b0;
                    r_p_sample <= '0;
                    r_p_avg    <= '0;
                    if (r_cnt != '0) begin
                        r_p_status <= UPD_NEW;
                        r_state    <= S_DIV;
                    end else begin
                        r_p_status <= w_timed_out ? UPD_TIMEOUT : UPD_NOTHING;
                        r_state    <= S_EMIT;
                    end
                end

                S_DIV: begin
                    if (w_div_done) begin
                        r_p_avg <= w_div_quo;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_last  <= r_now;
                        r_state <= S_EMIT;
                    end
                end

                S_EMIT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_kind   <= r_p_kind;
                        r_o_good   <= r_p_good;
                        r_o_sample <= r_p_sample;
                        r_o_avg    <= r_p_avg;
                        r_o_status <= r_p_status;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.result_kind = r_o_kind;
    assign o_res.frame_good  = r_o_good;
    assign o_res.sample_cm   = r_o_sample;
    assign o_res.average_cm  = r_o_avg;
    assign o_res.upd_code    = r_o_status;

endmodule
